@@ sv/wiau_pkg.sv @@
// ----------------------------------------------------------------------------
// wiau_pkg
// Shared types and constants for the wide integer arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wiau_pkg;

	localparam int WordBitsDefault = 128;
	localparam int HalfBits        = 64;
	localparam int DataInBits      = 256;
	localparam int DataOutBits     = 200;

	typedef enum logic [2:0] {
		ACT_ADD = 3'd0,
		ACT_SUB = 3'd1,
		ACT_CMP = 3'd2,
		ACT_MUL = 3'd3,
		ACT_DIV = 3'd4,
		ACT_SHL = 3'd5,
		ACT_SHR = 3'd6,
		ACT_AND = 3'd7
	} act_t;

	localparam logic [1:0] CMP_EQ   = 2'b00;
	localparam logic [1:0] CMP_GT   = 2'b01;
	localparam logic [1:0] CMP_LESS = 2'b11;

	// per-item control carried down the cell row
	typedef struct packed {
		act_t       act;
		logic       ovf;
		logic       dz;
		logic [1:0] cmp;
	} ctrl_t;

endpackage

`default_nettype wire

@@ sv/wide_integer_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// wide_integer_arithmetic_unit
// Unsigned W-bit add, subtract, compare, multiply, divide, shifts and AND.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while the output is not stalled, and each result
// passes through an entry stage, a row of W cells that each perform one
// restoring divide step or one shift-add multiply step, and an output register.
// The whole row advances together; while a result is held at the output with
// tready low, the row and the input stall, otherwise the row keeps taking items.
`default_nettype none

module wide_integer_arithmetic_unit #(
	parameter int W = wiau_pkg::WordBitsDefault
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// operand_a_hi, operand_a_lo, operand_b_hi, operand_b_lo
	input  wire logic [wiau_pkg::DataInBits-1:0] s_axis_tdata,
	// action
	input  wire logic [2:0]                      s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// result_hi, result_lo, remainder, compare_result, zero pad
	output logic [wiau_pkg::DataOutBits-1:0]     m_axis_tdata,
	// overflow, divide_by_zero
	output logic [1:0]                           m_axis_tuser
);

	logic            en;
	logic [127:0]    a_in, b_in;
	logic            valid_c [W+1];
	wiau_pkg::ctrl_t ctrl_c  [W+1];
	logic [W-1:0]    q_c     [W+1];
	logic [W-1:0]    acc_c   [W+1];
	logic [W-1:0]    opnd_c  [W+1];
	logic [63:0]     r_c     [W+1];
	logic            out_valid_q;
	logic [127:0]    res_q;
	logic [63:0]     rem_q;
	logic [1:0]      cmp_q;
	logic            ovf_q, dz_q;
	logic [W-1:0]    res_sel;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign a_in          = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
	assign b_in          = {s_axis_tdata[191:128], s_axis_tdata[255:192]};

	wiau_prep #(.W(W)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.act      (wiau_pkg::act_t'(s_axis_tuser)),
		.a_in     (a_in),
		.b_in     (b_in),
		.valid_s1 (valid_c[0]),
		.ctrl_s1  (ctrl_c[0]),
		.q_s1     (q_c[0]),
		.acc_s1   (acc_c[0]),
		.opnd_s1  (opnd_c[0]),
		.r_s1     (r_c[0])
	);

	for (genvar i = 0; i < W; i++) begin : g_cell
		wiau_cell #(.W(W)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (en),
			.in_valid    (valid_c[i]),
			.in_ctrl     (ctrl_c[i]),
			.in_q        (q_c[i]),
			.in_acc      (acc_c[i]),
			.in_opnd     (opnd_c[i]),
			.in_r        (r_c[i]),
			.out_valid_q (valid_c[i+1]),
			.out_ctrl_q  (ctrl_c[i+1]),
			.out_q_q     (q_c[i+1]),
			.out_acc_q   (acc_c[i+1]),
			.out_opnd_q  (opnd_c[i+1]),
			.out_r_q     (r_c[i+1])
		);
	end

	assign res_sel = (ctrl_c[W].act == wiau_pkg::ACT_DIV) ? q_c[W] : acc_c[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_c[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= 128'(res_sel);
			rem_q <= (ctrl_c[W].act == wiau_pkg::ACT_DIV) ? r_c[W] : 64'd0;
			cmp_q <= ctrl_c[W].cmp;
			ovf_q <= ctrl_c[W].ovf;
			dz_q  <= ctrl_c[W].dz;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, cmp_q, rem_q, res_q[63:0], res_q[127:64]};
	assign m_axis_tuser  = {dz_q, ovf_q};

endmodule

`default_nettype wire

@@ sv/wiau_prep.sv @@
// ----------------------------------------------------------------------------
// wiau_prep
// Entry stage: trims operands, computes the add, subtract, compare, shift and AND
// results directly and loads the working registers for the multiply and divide cells.
// ----------------------------------------------------------------------------
`default_nettype none

module wiau_prep #(
	parameter int W = wiau_pkg::WordBitsDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire wiau_pkg::act_t      act,
	input  wire logic [127:0]        a_in,
	input  wire logic [127:0]        b_in,
	output logic                     valid_s1,
	output wiau_pkg::ctrl_t          ctrl_s1,
	output logic [W-1:0]             q_s1,
	output logic [W-1:0]             acc_s1,
	output logic [W-1:0]             opnd_s1,
	output logic [63:0]              r_s1
);

	localparam int DivBits = (W > 64) ? 64 : W;

	logic [W-1:0]    a, b, b_short;
	logic [W:0]      sum;
	logic [W-1:0]    diff;
	wiau_pkg::ctrl_t ctrl_d;
	logic [W-1:0]    q_d, acc_d, opnd_d;

	assign a       = a_in[W-1:0];
	assign b       = b_in[W-1:0];
	assign b_short = W'(b[DivBits-1:0]);
	assign sum     = {1'b0, a} + {1'b0, b};
	assign diff    = a - b;

	always_comb begin
		ctrl_d     = '0;
		ctrl_d.act = act;
		q_d        = '0;
		acc_d      = '0;
		opnd_d     = '0;
		case (act)
			wiau_pkg::ACT_ADD: begin
				acc_d      = sum[W-1:0];
				ctrl_d.ovf = sum[W];
			end
			wiau_pkg::ACT_SUB: begin
				acc_d      = diff;
				ctrl_d.ovf = (a < b);
			end
			wiau_pkg::ACT_CMP: begin
				if (a > b)
					ctrl_d.cmp = wiau_pkg::CMP_GT;
				else if (a < b)
					ctrl_d.cmp = wiau_pkg::CMP_LESS;
				else
					ctrl_d.cmp = wiau_pkg::CMP_EQ;
			end
			wiau_pkg::ACT_MUL: begin
				// multiplier consumed msb first from q
				q_d    = b_short;
				opnd_d = a;
			end
			wiau_pkg::ACT_DIV: begin
				q_d       = a;
				opnd_d    = b_short;
				ctrl_d.dz = (b_short == '0);
			end
			wiau_pkg::ACT_SHL: acc_d = a << 1;
			wiau_pkg::ACT_SHR: acc_d = a >> 1;
			wiau_pkg::ACT_AND: acc_d = a & b;
			default:           acc_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1 <= ctrl_d;
			q_s1    <= q_d;
			acc_s1  <= acc_d;
			opnd_s1 <= opnd_d;
			r_s1    <= '0;
		end
	end

endmodule

`default_nettype wire

@@ sv/wiau_cell.sv @@
// ----------------------------------------------------------------------------
// wiau_cell
// One step of the row: a restoring divide step or a shift-add multiply step,
// other actions pass through.
// ----------------------------------------------------------------------------
`default_nettype none

module wiau_cell #(
	parameter int W = wiau_pkg::WordBitsDefault
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       in_valid,
	input  wire wiau_pkg::ctrl_t in_ctrl,
	input  wire logic [W-1:0] in_q,
	input  wire logic [W-1:0] in_acc,
	input  wire logic [W-1:0] in_opnd,
	input  wire logic [63:0]  in_r,
	output logic            out_valid_q,
	output wiau_pkg::ctrl_t out_ctrl_q,
	output logic [W-1:0]    out_q_q,
	output logic [W-1:0]    out_acc_q,
	output logic [W-1:0]    out_opnd_q,
	output logic [63:0]     out_r_q
);

	localparam int DivBits = (W > 64) ? 64 : W;

	logic [64:0]     t, d65;
	logic [W-1:0]    p_sh;
	logic [W:0]      psum;
	wiau_pkg::ctrl_t ctrl_d;
	logic [W-1:0]    q_d, acc_d;
	logic [63:0]     r_d;

	assign t     = {in_r, in_q[W-1]};
	assign d65   = 65'(in_opnd[DivBits-1:0]);
	assign p_sh  = in_acc << 1;
	assign psum  = {1'b0, p_sh} + {1'b0, in_opnd};

	always_comb begin
		ctrl_d = in_ctrl;
		q_d    = in_q;
		acc_d  = in_acc;
		r_d    = in_r;
		case (in_ctrl.act)
			wiau_pkg::ACT_DIV: begin
				if (t >= d65) begin
					r_d = 64'(t - d65);
					q_d = {in_q[W-2:0], 1'b1};
				end else begin
					r_d = t[63:0];
					q_d = {in_q[W-2:0], 1'b0};
				end
			end
			wiau_pkg::ACT_MUL: begin
				// bits leaving the top never come back
				ctrl_d.ovf = in_ctrl.ovf | in_acc[W-1];
				if (in_q[W-1]) begin
					acc_d      = psum[W-1:0];
					ctrl_d.ovf = in_ctrl.ovf | in_acc[W-1] | psum[W];
				end else begin
					acc_d = p_sh;
				end
				q_d = {in_q[W-2:0], 1'b0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ctrl_q <= ctrl_d;
			out_q_q    <= q_d;
			out_acc_q  <= acc_d;
			out_opnd_q <= in_opnd;
			out_r_q    <= r_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/wiau_checker.sv @@
// ----------------------------------------------------------------------------
// wiau_checker
// Port-level checks for the wide integer arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

module wiau_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [199:0] m_axis_tdata,
	input wire logic [1:0]   m_axis_tuser
);

	// held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// input stalls exactly when a result is held
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	// divide by zero only comes from div, which sets no other flag
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] &&
		m_axis_tdata[193:192] == 2'b00)
		else $error("divide by zero mixed with other status");

	// compare code never reads as minus two, and the zero pad stays zero
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[193:192] != 2'b10 && m_axis_tdata[199:194] == 6'd0)
		else $error("bad compare code or pad");

endmodule

bind wide_integer_arithmetic_unit wiau_checker u_wiau_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 128-bit wide integer arithmetic unit: directed
// corner items for every action, a long random part, a long receiver hold-off
// that fills the row of cells, and a drain pause, all against an in-bench
// predictor, with every result compared field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
	import wiau_pkg::*;

	localparam int W         = 128;
	localparam int Latency   = W + 2;
	localparam int CycleCap  = 3000000;
	localparam int HoldOff   = 400;
	localparam logic [63:0] Ones64 = '1;
	localparam logic [63:0] Top64  = 64'h8000_0000_0000_0000;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] rem;
		logic [1:0]  cmp;
		logic        ovf;
		logic        dz;
	} alu_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [DataInBits-1:0] s_axis_tdata = '0;
	logic [2:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [DataOutBits-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	alu_result_t pending_results[$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int act_count[8];
	int cycles = 0;
	bit sink_idle_on = 1'b0;
	bit src_idle_on = 1'b0;
	bit hold_req = 1'b0;

	wide_integer_arithmetic_unit #(.W(W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #6 clk = ~clk;

	function automatic alu_result_t compute_outcome(act_t act, logic [127:0] a, logic [127:0] b);
		alu_result_t res;
		logic [128:0] sum;
		logic [191:0] prod;
		logic [127:0] q;
		logic [63:0] r;
		logic [63:0] dv;
		logic carry;
		logic [127:0] v;
		res = '{default: '0};
		v = '0;
		dv = b[63:0];
		case (act)
			ACT_ADD: begin
				sum = {1'b0, a} + {1'b0, b};
				v = sum[127:0];
				res.ovf = sum[128];
			end
			ACT_SUB: begin
				v = a - b;
				res.ovf = a < b;
			end
			ACT_CMP: begin
				res.cmp = (a > b) ? CMP_GT : ((a < b) ? CMP_LESS : CMP_EQ);
			end
			ACT_MUL: begin
				prod = {64'd0, a} * {128'd0, dv};
				v = prod[127:0];
				res.ovf = |prod[191:128];
			end
			ACT_DIV: begin
				// restoring steps with a 65-bit partial remainder (carry + r)
				q = a;
				r = '0;
				for (int i = 0; i < W; i++) begin
					carry = r[63];
					r = {r[62:0], q[127]};
					q = {q[126:0], 1'b0};
					if (carry || r >= dv) begin
						r = r - dv;
						q[0] = 1'b1;
					end
				end
				v = q;
				res.rem = r;
				res.dz = (dv == '0);
			end
			ACT_SHL: v = a << 1;
			ACT_SHR: v = a >> 1;
			default: v = a & b;
		endcase
		res.hi = v[127:64];
		res.lo = v[63:0];
		return res;
	endfunction

	function automatic logic [63:0] pick_half();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return Ones64;
			2: return Top64 | {32'd0, $urandom};
			3: return 64'($urandom_range(1, 255));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// sender: drive at the falling edge, wait for acceptance at the rising edge
	task automatic send_item(act_t act, logic [63:0] ah, logic [63:0] al,
			logic [63:0] bh, logic [63:0] bl);
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = act;
		s_axis_tdata = {bl, bh, al, ah};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(compute_outcome(act, {ah, al}, {bh, bl}));
		act_count[act]++;
		items_sent++;
	endtask

	task automatic source_gap();
		int n;
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 13);
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic source_stop();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(ACT_ADD, Ones64, Ones64, 64'd0, 64'd1);
		send_item(ACT_ADD, Ones64, Ones64, Ones64, Ones64);
		send_item(ACT_ADD, 64'd0, Ones64, 64'd0, 64'd1);
		send_item(ACT_SUB, 64'd0, 64'd0, 64'd0, 64'd1);
		send_item(ACT_SUB, Ones64, Ones64, Ones64, Ones64);
		send_item(ACT_SUB, 64'd1, 64'd0, 64'd0, 64'd1);
		send_item(ACT_CMP, 64'd5, 64'd7, 64'd5, 64'd7);
		send_item(ACT_CMP, 64'd5, 64'd6, 64'd5, 64'd7);
		send_item(ACT_CMP, 64'd6, 64'd0, 64'd5, Ones64);
		send_item(ACT_CMP, 64'd0, Ones64, 64'd1, 64'd0);
		send_item(ACT_MUL, Ones64, Ones64, Ones64, Ones64);
		send_item(ACT_MUL, 64'd0, Ones64, 64'd0, Ones64);
		send_item(ACT_MUL, 64'd1, 64'd0, 64'd0, Top64);
		send_item(ACT_DIV, Ones64, Ones64, 64'd0, 64'd0);
		send_item(ACT_DIV, 64'h1234, 64'h5678_9abc, Ones64, 64'd0);
		send_item(ACT_DIV, Ones64, Ones64, 64'd0, Ones64);
		send_item(ACT_DIV, Ones64, 64'd3, 64'd0, Top64);
		send_item(ACT_DIV, 64'd0, 64'd100, 64'd0, 64'd7);
		send_item(ACT_DIV, Ones64, Ones64, 64'd0, 64'd1);
		send_item(ACT_SHL, Top64, Top64, 64'd0, 64'd0);
		send_item(ACT_SHR, 64'd1, 64'd1, 64'd0, 64'd0);
		send_item(ACT_AND, Ones64, Ones64, 64'h0f0f, Ones64);
		send_item(ACT_AND, Ones64, 64'd0, 64'd0, Ones64);
		source_stop();
	endtask

	task automatic test_random(int count);
		act_t act;
		logic [63:0] bl;
		for (int i = 0; i < count; i++) begin
			act = act_t'($urandom_range(0, 7));
			bl = pick_half();
			if (act == ACT_DIV && $urandom_range(0, 15) == 0) bl = '0;
			send_item(act, pick_half(), pick_half(), pick_half(), bl);
			source_gap();
		end
		source_stop();
	endtask

	// receiver holds off while the sender keeps offering, so input backs up
	task automatic test_hold_off();
		hold_req = 1'b1;
		for (int i = 0; i < 300; i++)
			send_item(act_t'($urandom_range(0, 7)), pick_half(), pick_half(),
				pick_half(), pick_half());
		source_stop();
		hold_req = 1'b0;
	endtask

	task automatic test_drain_pause();
		wait_drained();
		for (int i = 0; i < 20; i++)
			send_item(ACT_DIV, pick_half(), pick_half(), 64'd0, pick_half());
		source_stop();
	endtask

	// receiver readiness
	initial begin
		int stall;
		int held;
		stall = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (hold_req && held < HoldOff) begin
				held++;
				m_axis_tready = 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready = 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 12);
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_axis_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[63:0] !== want.hi) begin
					$display("%0t: result_hi expected %h actual %h", $time, want.hi,
						m_axis_tdata[63:0]);
					errors++;
				end
				if (m_axis_tdata[127:64] !== want.lo) begin
					$display("%0t: result_lo expected %h actual %h", $time, want.lo,
						m_axis_tdata[127:64]);
					errors++;
				end
				if (m_axis_tdata[191:128] !== want.rem) begin
					$display("%0t: remainder expected %h actual %h", $time, want.rem,
						m_axis_tdata[191:128]);
					errors++;
				end
				if (m_axis_tdata[193:192] !== want.cmp) begin
					$display("%0t: compare expected %b actual %b", $time, want.cmp,
						m_axis_tdata[193:192]);
					errors++;
				end
				if (m_axis_tuser[0] !== want.ovf) begin
					$display("%0t: overflow expected %b actual %b", $time, want.ovf,
						m_axis_tuser[0]);
					errors++;
				end
				if (m_axis_tuser[1] !== want.dz) begin
					$display("%0t: divide_by_zero expected %b actual %b", $time, want.dz,
						m_axis_tuser[1]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleCap) begin
			$display("timeout after %0d cycles", cycles);
			$display("wide_integer_arithmetic_unit verification failed");
			$finish;
		end
	end

	initial begin
		int tail;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		sink_idle_on = 1'b1;
		src_idle_on = 1'b1;
		test_directed();
		test_random(700);
		test_hold_off();
		test_drain_pause();
		test_random(300);
		sink_idle_on = 1'b0;
		src_idle_on = 1'b0;
		test_random(200);
		wait_drained();
		tail = 0;
		while (tail < Latency + 20) begin
			@(posedge clk);
			tail++;
		end
		$display("%0d items sent, %0d results checked", items_sent, results_seen);
		$display("per action add..and: %0d %0d %0d %0d %0d %0d %0d %0d", act_count[0],
			act_count[1], act_count[2], act_count[3], act_count[4], act_count[5],
			act_count[6], act_count[7]);
		if (errors == 0 && pending_results.size() == 0)
			$display("wide_integer_arithmetic_unit verification clean");
		else
			$display("wide_integer_arithmetic_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
sv/wiau_pkg.sv
sv/wiau_prep.sv
sv/wiau_cell.sv
sv/wide_integer_arithmetic_unit.sv
sv/wiau_checker.sv
bench/tb.sv
